@@ design/nimt_pkg.sv @@
// Shared types and constants of the neighbour IP/MAC table.
// Item layouts, opcode and status codes, controller/datapath command bundles.
// No dependencies.
`default_nettype none

package nimt_pkg;

    localparam int TABLE_SIZE_DEF  = 256;
    localparam int FETCH_LIMIT_DEF = 64;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int MAC_W    = 48;
    localparam int START_W  = 9;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int NEXT_W   = 9;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_UPDATE   = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_LIST     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   ip_key;
        logic [MAC_W-1:0]   new_mac;
        logic [START_W-1:0] start_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    entry_ip;
        logic [MAC_W-1:0]    entry_mac;
        logic [COUNT_W-1:0]  listed_count;
        logic [NEXT_W-1:0]   next_start;
        logic                last;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic              cap_in;    // latch the accepted item
        logic              rd_en;     // read key/mac at the scan address
        logic              wr_new;    // write a new entry at the address, bump fill
        logic              wr_mac;    // overwrite the mac at the address
        logic              out_load;  // load the result register
        t_status           status;
        logic              slot_en;   // slot field from the address, else zero
        logic              entry_en;  // ip/mac fields from read data, else zero
        logic              last;
        logic [COUNT_W-1:0] count;
        logic [NEXT_W-1:0]  next_start;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic               out_free;
        logic               match;
        t_op                op;
        logic [START_W-1:0] start;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/nimt_if.sv @@
// Valid/ready channel interfaces for request and result items.
// Depends on nimt_pkg.
`default_nettype none

interface nimt_req_if;
    import nimt_pkg::*;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nimt_rsp_if;
    import nimt_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/nimt_dpath.sv @@
// Datapath of the neighbour table: key/mac memories, fill count, item latch,
// registered read data and the result register. Depends on nimt_pkg.
`default_nettype none

module nimt_dpath #(
    parameter int TABLE_SIZE = nimt_pkg::TABLE_SIZE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  nimt_pkg::t_req                        i_in_data,
    input  nimt_pkg::t_dp_cmd                     i_cmd,
    input  logic [$clog2(TABLE_SIZE)-1:0]         i_addr,
    output nimt_pkg::t_dp_stat                    o_stat,
    output logic [$clog2(TABLE_SIZE+1)-1:0]       o_fill,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output nimt_pkg::t_rsp                        o_out_data
);
    import nimt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SIZE + 1);

    t_req             r_item;
    logic [KEY_W-1:0] r_key_mem [TABLE_SIZE];
    logic [MAC_W-1:0] r_mac_mem [TABLE_SIZE];
    logic [KEY_W-1:0] r_rd_key;
    logic [MAC_W-1:0] r_rd_mac;
    logic [CNT_W-1:0] r_fill;
    logic             r_out_valid;
    t_rsp             r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            r_key_mem[i_addr] <= r_item.ip_key;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new || i_cmd.wr_mac) begin
            r_mac_mem[i_addr] <= r_item.new_mac;
        end
        if (i_cmd.rd_en) begin
            r_rd_mac <= r_mac_mem[i_addr];
        end
    end

    // slots fill from the bottom and are never freed: valid means below fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.wr_new) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status       <= i_cmd.status;
            r_out.slot         <= i_cmd.slot_en ? SLOT_W'(i_addr) : '0;
            r_out.entry_ip     <= i_cmd.entry_en ? r_rd_key : '0;
            r_out.entry_mac    <= i_cmd.entry_en ? r_rd_mac : '0;
            r_out.listed_count <= i_cmd.count;
            r_out.next_start   <= i_cmd.next_start;
            r_out.last         <= i_cmd.last;
        end
    end

    always_comb begin
        o_stat.out_free = !r_out_valid || i_out_ready;
        o_stat.match    = (r_rd_key == r_item.ip_key);
        o_stat.op       = t_op'(r_item.op);
        o_stat.start    = r_item.start_index;
    end

    assign o_fill      = r_fill;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ design/nimt_ctrl.sv @@
// Controller of the neighbour table: scans slots one per read, decides the
// result of each item and paces result transfers. Depends on nimt_pkg.
`default_nettype none

module nimt_ctrl #(
    parameter int TABLE_SIZE  = nimt_pkg::TABLE_SIZE_DEF,
    parameter int FETCH_LIMIT = nimt_pkg::FETCH_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  nimt_pkg::t_dp_stat                i_stat,
    input  logic [$clog2(TABLE_SIZE+1)-1:0]   i_fill,
    output nimt_pkg::t_dp_cmd                 o_cmd,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_addr
);
    import nimt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CMP_W = (CNT_W > START_W) ? CNT_W : START_W;
    localparam logic [NEXT_W-1:0]  NEXT_END  = NEXT_W'(TABLE_SIZE + 1);
    localparam logic [COUNT_W-1:0] LIMIT_CNT = COUNT_W'(FETCH_LIMIT);
    localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(TABLE_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CHECK,
        S_FINISH,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_n;
    t_status            r_status;
    logic               r_slot_en;
    logic               r_entry_en;
    logic               r_last;
    logic [COUNT_W-1:0] r_count;
    logic [NEXT_W-1:0]  r_next;

    logic               accept;
    logic               scan_done;
    logic               full;
    logic [CNT_W-1:0]   start_sat;
    logic [CNT_W-1:0]   pos_inc;
    logic [COUNT_W-1:0] n_inc;

    always_comb begin
        accept    = i_in_valid && (r_state == S_IDLE);
        scan_done = (r_pos >= i_fill);
        full      = (i_fill == FULL_CNT);
        pos_inc   = r_pos + 1'b1;
        n_inc     = r_n + 1'b1;
        start_sat = (CMP_W'(i_stat.start) > CMP_W'(TABLE_SIZE)) ? FULL_CNT
                                                                 : CNT_W'(i_stat.start);
    end

    always_comb begin
        o_cmd.cap_in     = accept;
        o_cmd.rd_en      = (r_state == S_READ) && !scan_done;
        o_cmd.wr_new     = (r_state == S_FINISH) && (i_stat.op == OP_REGISTER) && !full;
        o_cmd.wr_mac     = (r_state == S_CHECK) && (i_stat.op == OP_UPDATE) && i_stat.match;
        o_cmd.out_load   = (r_state == S_EMIT) && i_stat.out_free;
        o_cmd.status     = r_status;
        o_cmd.slot_en    = r_slot_en;
        o_cmd.entry_en   = r_entry_en;
        o_cmd.last       = r_last;
        o_cmd.count      = r_count;
        o_cmd.next_start = r_next;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_addr     = r_pos[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_pos   <= (i_stat.op == OP_LIST) ? start_sat : '0;
                    r_n     <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= scan_done ? S_FINISH : S_CHECK;
                end
                S_CHECK: begin
                    if (i_stat.op == OP_LIST) begin
                        // every slot below fill is valid, so the final entry is known here
                        r_status   <= ST_OK;
                        r_slot_en  <= 1'b1;
                        r_entry_en <= 1'b1;
                        if (n_inc == LIMIT_CNT) begin
                            r_last  <= 1'b1;
                            r_count <= n_inc;
                            r_next  <= NEXT_W'(pos_inc);
                        end else if (pos_inc == i_fill) begin
                            r_last  <= 1'b1;
                            r_count <= n_inc;
                            r_next  <= NEXT_END;
                        end else begin
                            r_last  <= 1'b0;
                            r_count <= '0;
                            r_next  <= '0;
                        end
                        r_state <= S_EMIT;
                    end else if (i_stat.match) begin
                        r_status   <= (i_stat.op == OP_REGISTER) ? ST_PRESENT : ST_OK;
                        r_slot_en  <= (i_stat.op != OP_REGISTER);
                        r_entry_en <= 1'b0;
                        r_last     <= 1'b1;
                        r_count    <= '0;
                        r_next     <= '0;
                        r_state    <= S_EMIT;
                    end else begin
                        r_pos   <= pos_inc;
                        r_state <= S_READ;
                    end
                end
                S_FINISH: begin
                    r_entry_en <= 1'b0;
                    r_last     <= 1'b1;
                    r_count    <= '0;
                    case (i_stat.op)
                        OP_REGISTER: begin
                            // scan stopped at the fill count, which is the new slot
                            r_status  <= full ? ST_FULL : ST_OK;
                            r_slot_en <= !full;
                            r_next    <= '0;
                        end
                        OP_LIST: begin
                            r_status  <= ST_EMPTY;
                            r_slot_en <= 1'b0;
                            r_next    <= NEXT_END;
                        end
                        default: begin
                            r_status  <= ST_NOTFOUND;
                            r_slot_en <= 1'b0;
                            r_next    <= '0;
                        end
                    endcase
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= pos_inc;
                            r_n     <= n_inc;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/neighbour_ip_mac_table.sv @@
// Neighbour IP/MAC table: register, update, search and list over TABLE_SIZE slots.
// Register/update/search scan the filled slots through one memory read port,
// reading and then checking each slot examined; a miss scans all F filled slots.
// List: each listed entry is read, checked and emitted in turn, longer while results stall.
// One item at a time. Reset clears the fill count, so the table is empty at once.
// Depends on nimt_pkg, nimt_if, nimt_dpath, nimt_ctrl.
`default_nettype none

module neighbour_ip_mac_table #(
    parameter int TABLE_SIZE  = nimt_pkg::TABLE_SIZE_DEF,
    parameter int FETCH_LIMIT = nimt_pkg::FETCH_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nimt_req_if.sink    i_req,
    nimt_rsp_if.source  o_rsp
);
    import nimt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int IDX_W = $clog2(TABLE_SIZE);

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic [CNT_W-1:0] dp_fill;
    logic [IDX_W-1:0] dp_addr;
    logic             in_ready;
    logic             out_valid;
    t_rsp             out_data;

    nimt_ctrl #(
        .TABLE_SIZE  (TABLE_SIZE),
        .FETCH_LIMIT (FETCH_LIMIT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .i_fill     (dp_fill),
        .o_cmd      (dp_cmd),
        .o_addr     (dp_addr)
    );

    nimt_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_req.data),
        .i_cmd       (dp_cmd),
        .i_addr      (dp_addr),
        .o_stat      (dp_stat),
        .o_fill      (dp_fill),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_fill <= CNT_W'(TABLE_SIZE))
        else $error("fill count beyond table size");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (dp_fill != $past(dp_fill)))
        |-> (dp_fill == $past(dp_fill) + 1'b1))
        else $error("fill count moved by other than one");

    a_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_data.last)
        |-> (out_data.status == ST_OK && out_data.listed_count == '0
             && out_data.next_start == '0))
        else $error("non-final result is not a plain listed entry");

    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && (out_data.status == ST_PRESENT || out_data.status == ST_FULL
                       || out_data.status == ST_NOTFOUND))
        |-> (out_data.slot == '0 && out_data.last))
        else $error("failed operation carries a slot or is not final");

endmodule

`default_nettype wire
